/* hdl/obc_pkg.sv */
// ----------------------------------------------------------------------------
// obc_pkg
// shared types and constants of the oriented box overlap pipeline
// ----------------------------------------------------------------------------
package obc_pkg;

  localparam int unsigned TrigFracBits = 14;
  localparam int unsigned TrigFracMax  = 20;

  // centre difference, projections and radii
  localparam int unsigned DxW   = 24 + TrigFracMax + 4;
  localparam int unsigned AxW   = 17;
  localparam int unsigned DotW  = 36;
  localparam int unsigned MagW  = DotW - 1;
  localparam int unsigned RadW  = 53;
  localparam int unsigned ExtW  = 35;
  localparam int unsigned DistW = DxW + AxW + 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] RegBaseToFront = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBaseToBack  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCarWidth    = 2'd2;

  localparam logic [13:0] BaseToFrontRst = 14'd3800;
  localparam logic [13:0] BaseToBackRst  = 14'd1000;
  localparam logic [12:0] CarWidthRst    = 13'd1900;

  localparam logic [2:0] DecAabb     = 3'd0;
  localparam logic [2:0] DecAxisBase = 3'd1;
  localparam logic [2:0] DecNone     = 3'd5;

  typedef struct packed {
    logic [13:0] front_len;
    logic [13:0] rear_len;
    logic [12:0] car_width;
  } cfg_t;

  // dot[k]: 0 ego length, 1 ego width, 2 obstacle length, 3 obstacle width
  typedef struct packed {
    logic [15:0]                    cl;
    logic [13:0]                    cw;
    logic [15:0]                    ol;
    logic [15:0]                    ow;
    logic signed [15:0]             ec;
    logic signed [15:0]             es;
    logic signed [15:0]             oc;
    logic signed [15:0]             os;
    logic signed [23:0]             ex;
    logic signed [23:0]             ey;
    logic signed [23:0]             ox;
    logic signed [23:0]             oy;
    logic signed [31:0]             off_ec;
    logic signed [31:0]             off_es;
    logic [3:0][AxW-1:0]            nx;
    logic [3:0][AxW-1:0]            ny;
    logic [3:0][3:0][DotW-1:0]      dot;
  } s1_t;

  typedef struct packed {
    logic signed [DxW-1:0]          dx;
    logic signed [DxW-1:0]          dy;
    logic [3:0][AxW-1:0]            nx;
    logic [3:0][AxW-1:0]            ny;
    logic [3:0][RadW-1:0]           rsum;
    logic [ExtW-1:0]                extx;
    logic [ExtW-1:0]                exty;
  } s2_t;

  typedef struct packed {
    logic [3:0][DistW-1:0]          proj;
    logic [3:0][RadW-1:0]           rsum;
    logic                           aabb_sep;
  } s3_t;

endpackage

/* hdl/obc_if.sv */
// ----------------------------------------------------------------------------
// obc_in_if / obc_out_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface obc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] ego_x;
  logic signed [23:0] ego_y;
  logic signed [15:0] ego_cos;
  logic signed [15:0] ego_sin;
  logic [12:0]        inflate_w;
  logic [12:0]        inflate_l;
  logic signed [23:0] obs_x;
  logic signed [23:0] obs_y;
  logic [15:0]        obs_width;
  logic [15:0]        obs_length;
  logic signed [15:0] obs_cos;
  logic signed [15:0] obs_sin;

  modport source (output valid, ego_x, ego_y, ego_cos, ego_sin, inflate_w, inflate_l,
                  obs_x, obs_y, obs_width, obs_length, obs_cos, obs_sin, input ready);
  modport sink   (input valid, ego_x, ego_y, ego_cos, ego_sin, inflate_w, inflate_l,
                  obs_x, obs_y, obs_width, obs_length, obs_cos, obs_sin, output ready);
endinterface

interface obc_out_if;
  logic       valid;
  logic       ready;
  logic       collision;
  logic [2:0] decided_by;

  modport source (output valid, collision, decided_by, input ready);
  modport sink   (input valid, collision, decided_by, output ready);
endinterface

/* hdl/obb_collision_sat.sv */
// a result reaches out_o through the prep, radius, proj and decide stage registers
// throughput: one request per cycle while out_o is ready, each of the four stages holds one request
// a stalled output only holds back the stages behind a full stage
// reset clears all stage valid bits and loads the vehicle dimension defaults
// ----------------------------------------------------------------------------
// obb_collision_sat
// oriented box overlap: bounding box reject then separating axis test
// ----------------------------------------------------------------------------
module obb_collision_sat #(
  parameter int unsigned TRIG_FRAC_BITS = obc_pkg::TrigFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [obc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [obc_pkg::CfgDataW-1:0] cfg_wdata_i,
  obc_in_if.sink                       in_i,
  obc_out_if.source                    out_o
);

  obc_pkg::cfg_t cfg_q;
  obc_pkg::s1_t  s1;
  obc_pkg::s2_t  s2;
  obc_pkg::s3_t  s3;
  logic          v1, r1, v2, r2, v3, r3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_len <= obc_pkg::BaseToFrontRst;
      cfg_q.rear_len  <= obc_pkg::BaseToBackRst;
      cfg_q.car_width <= obc_pkg::CarWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        obc_pkg::RegBaseToFront: cfg_q.front_len <= cfg_wdata_i;
        obc_pkg::RegBaseToBack:  cfg_q.rear_len  <= cfg_wdata_i;
        obc_pkg::RegCarWidth:    cfg_q.car_width <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  obc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .valid_o (v1),
    .ready_i (r1),
    .data_o  (s1)
  );

  obc_radius #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .data_i  (s1),
    .valid_o (v2),
    .ready_i (r2),
    .data_o  (s2)
  );

  obc_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .data_i  (s2),
    .valid_o (v3),
    .ready_i (r3),
    .data_o  (s3)
  );

  obc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (r3),
    .data_i  (s3),
    .out_o   (out_o)
  );

endmodule

/* hdl/obc_prep.sv */
// ----------------------------------------------------------------------------
// obc_prep
// stage 1: box dimensions, axes and trig dot products
// ----------------------------------------------------------------------------
module obc_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  obc_pkg::cfg_t cfg_i,
  obc_in_if.sink        in_i,
  output logic          valid_o,
  input  logic          ready_i,
  output obc_pkg::s1_t  data_o
);

  localparam int unsigned DotW = obc_pkg::DotW;
  localparam int unsigned AxW  = obc_pkg::AxW;

  function automatic logic [DotW-1:0] dot2(logic signed [AxW-1:0] a, logic signed [AxW-1:0] b,
                                           logic signed [AxW-1:0] c, logic signed [AxW-1:0] d);
    logic signed [DotW-1:0] ae, be, ce, de;
    ae = DotW'(a);
    be = DotW'(b);
    ce = DotW'(c);
    de = DotW'(d);
    return ae * be + ce * de;
  endfunction

  logic                 valid_q;
  obc_pkg::s1_t         data_d, data_q;
  logic signed [14:0]   off;
  logic signed [AxW-1:0] ec, es, oc, os, nes, nos;
  logic signed [AxW-1:0] nx [4];
  logic signed [AxW-1:0] ny [4];

  assign in_i.ready = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_comb begin
    ec  = AxW'(in_i.ego_cos);
    es  = AxW'(in_i.ego_sin);
    oc  = AxW'(in_i.obs_cos);
    os  = AxW'(in_i.obs_sin);
    nes = -es;
    nos = -os;
    nx[0] = ec;  ny[0] = es;
    nx[1] = nes; ny[1] = ec;
    nx[2] = oc;  ny[2] = os;
    nx[3] = nos; ny[3] = oc;
    off = $signed({1'b0, cfg_i.front_len}) - $signed({1'b0, cfg_i.rear_len});

    data_d.cl = 16'(cfg_i.front_len) + 16'(cfg_i.rear_len) + 16'(in_i.inflate_l);
    data_d.cw = 14'(cfg_i.car_width) + 14'(in_i.inflate_w);
    data_d.ol = in_i.obs_length;
    data_d.ow = in_i.obs_width;
    data_d.ec = in_i.ego_cos;
    data_d.es = in_i.ego_sin;
    data_d.oc = in_i.obs_cos;
    data_d.os = in_i.obs_sin;
    data_d.ex = in_i.ego_x;
    data_d.ey = in_i.ego_y;
    data_d.ox = in_i.obs_x;
    data_d.oy = in_i.obs_y;
    data_d.off_ec = 32'(off) * 32'(in_i.ego_cos);
    data_d.off_es = 32'(off) * 32'(in_i.ego_sin);
    for (int k = 0; k < 4; k++) begin
      data_d.nx[k]     = nx[k];
      data_d.ny[k]     = ny[k];
      data_d.dot[k][0] = dot2(ec, nx[k], es, ny[k]);
      data_d.dot[k][1] = dot2(nes, nx[k], ec, ny[k]);
      data_d.dot[k][2] = dot2(oc, nx[k], os, ny[k]);
      data_d.dot[k][3] = dot2(nos, nx[k], oc, ny[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

endmodule

/* hdl/obc_radius.sv */
// ----------------------------------------------------------------------------
// obc_radius
// stage 2: centre difference, box radii per axis and bounding box extents
// ----------------------------------------------------------------------------
module obc_radius #(
  parameter int unsigned TRIG_FRAC_BITS = obc_pkg::TrigFracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  obc_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output obc_pkg::s2_t data_o
);

  localparam int unsigned DxW  = obc_pkg::DxW;
  localparam int unsigned DotW = obc_pkg::DotW;
  localparam int unsigned MagW = obc_pkg::MagW;
  localparam int unsigned RadW = obc_pkg::RadW;
  localparam int unsigned ExtW = obc_pkg::ExtW;

  function automatic logic [MagW-1:0] mag(logic [DotW-1:0] v);
    logic signed [DotW-1:0] sv;
    logic [DotW-1:0]        a;
    sv = $signed(v);
    a  = sv[DotW-1] ? DotW'(-sv) : v;
    return a[MagW-1:0];
  endfunction

  function automatic logic [15:0] tmag(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  logic                  valid_q;
  obc_pkg::s2_t          data_d, data_q;
  logic signed [DxW-1:0] cx, cy, px, py;
  logic [RadW-1:0]       ra, rb;
  logic [15:0]           aec, aes, aoc, aos;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    cx = (DxW'(data_i.ex) <<< (TRIG_FRAC_BITS + 1)) + DxW'(data_i.off_ec);
    cy = (DxW'(data_i.ey) <<< (TRIG_FRAC_BITS + 1)) + DxW'(data_i.off_es);
    px = DxW'(data_i.ox) <<< (TRIG_FRAC_BITS + 1);
    py = DxW'(data_i.oy) <<< (TRIG_FRAC_BITS + 1);
    data_d.dx = px - cx;
    data_d.dy = py - cy;
    data_d.nx = data_i.nx;
    data_d.ny = data_i.ny;
    for (int k = 0; k < 4; k++) begin
      ra = RadW'(data_i.cl) * RadW'(mag(data_i.dot[k][0]))
         + RadW'(data_i.cw) * RadW'(mag(data_i.dot[k][1]));
      rb = RadW'(data_i.ol) * RadW'(mag(data_i.dot[k][2]))
         + RadW'(data_i.ow) * RadW'(mag(data_i.dot[k][3]));
      data_d.rsum[k] = ra + rb;
    end
    aec = tmag(data_i.ec);
    aes = tmag(data_i.es);
    aoc = tmag(data_i.oc);
    aos = tmag(data_i.os);
    data_d.extx = ExtW'(data_i.cl) * ExtW'(aec) + ExtW'(data_i.cw) * ExtW'(aes)
                + ExtW'(data_i.ol) * ExtW'(aoc) + ExtW'(data_i.ow) * ExtW'(aos);
    data_d.exty = ExtW'(data_i.cl) * ExtW'(aes) + ExtW'(data_i.cw) * ExtW'(aec)
                + ExtW'(data_i.ol) * ExtW'(aos) + ExtW'(data_i.ow) * ExtW'(aoc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* hdl/obc_proj.sv */
// ----------------------------------------------------------------------------
// obc_proj
// stage 3: centre distance projected on each axis, bounding box check
// ----------------------------------------------------------------------------
module obc_proj (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  obc_pkg::s2_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output obc_pkg::s3_t data_o
);

  localparam int unsigned DxW   = obc_pkg::DxW;
  localparam int unsigned AxW   = obc_pkg::AxW;
  localparam int unsigned DistW = obc_pkg::DistW;

  logic                    valid_q;
  obc_pkg::s3_t            data_d, data_q;
  logic signed [DistW-1:0] p;
  logic signed [AxW-1:0]   nx, ny;
  logic [DxW-1:0]          adx, ady;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nx = $signed(data_i.nx[k]);
      ny = $signed(data_i.ny[k]);
      p  = DistW'(data_i.dx) * DistW'(nx) + DistW'(data_i.dy) * DistW'(ny);
      data_d.proj[k] = p[DistW-1] ? DistW'(-p) : DistW'(p);
    end
    data_d.rsum = data_i.rsum;
    adx = data_i.dx[DxW-1] ? DxW'(-data_i.dx) : DxW'(data_i.dx);
    ady = data_i.dy[DxW-1] ? DxW'(-data_i.dy) : DxW'(data_i.dy);
    data_d.aabb_sep = (adx > DxW'(data_i.extx)) || (ady > DxW'(data_i.exty));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* hdl/obc_decide.sv */
// ----------------------------------------------------------------------------
// obc_decide
// stage 4: first separating test wins, result register
// ----------------------------------------------------------------------------
module obc_decide (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  obc_pkg::s3_t data_i,
  obc_out_if.source    out_o
);

  localparam int unsigned DistW = obc_pkg::DistW;

  logic       valid_q;
  logic [2:0] dec_d, dec_q;

  assign ready_o          = !valid_q || out_o.ready;
  assign out_o.valid      = valid_q;
  assign out_o.decided_by = dec_q;
  assign out_o.collision  = (dec_q == obc_pkg::DecNone);

  always_comb begin
    dec_d = obc_pkg::DecNone;
    for (int k = 3; k >= 0; k--) begin
      if (data_i.proj[k] > DistW'(data_i.rsum[k])) begin
        dec_d = obc_pkg::DecAxisBase + 3'(k);
      end
    end
    if (data_i.aabb_sep) begin
      dec_d = obc_pkg::DecAabb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

endmodule
